[src/dsm_pkg.sv]
// Package for the two-digit segment multiplexer: command codes, segment tables,
// digit arithmetic helpers and the tick status struct.
// No dependencies; imported by every module of the block.
`default_nettype none

package dsm_pkg;

    // Default number of digits driven
    localparam int DIGIT_COUNT_DEF = 2;

    // Refresh divider after reset
    localparam logic [7:0] DIVIDER_RESET = 8'd2;

    // Stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 1;

    // Command codes carried in the input tuser
    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_NUM   = 3'd1,
        CMD_TEXT  = 3'd2,
        CMD_RAW   = 3'd3,
        CMD_DOTS  = 3'd4,
        CMD_DOT   = 3'd5,
        CMD_CLEAR = 3'd6
    } cmd_t;

    // Segment codes of the decimal digits
    localparam logic [7:0] NUM_CODES [10] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
    };

    localparam logic [7:0] CODE_C     = 8'h9C;
    localparam logic [7:0] CODE_A     = 8'hEE;
    localparam logic [7:0] CODE_CLOSE = 8'hF0;

    // Tick controller status toward the datapath
    typedef struct packed {
        logic emit;
        logic digit;
    } tick_status_t;

    // Quotient by ten through the reciprocal 205/2048, exact below 1029
    function automatic logic [4:0] div10(input logic [7:0] n);
        logic [15:0] p;
        p = {8'd0, n} * 16'd205;
        return p[15:11];
    endfunction

    // Remainder by ten
    function automatic logic [3:0] mod10(input logic [7:0] n);
        logic [4:0] q;
        logic [7:0] r;
        q = div10(n);
        r = n - ({3'd0, q} << 3) - ({3'd0, q} << 1);
        return r[3:0];
    endfunction

    // Segment code of one decimal digit, blank for anything above nine
    function automatic logic [7:0] num_code(input logic [3:0] d);
        logic [7:0] code;
        code = 8'h00;
        if (d < 4'd10)
        begin
            code = NUM_CODES[d];
        end
        return code;
    endfunction

    // Segment code of an ASCII character
    function automatic logic [7:0] char_code(input logic [7:0] c);
        logic [7:0] code;
        code = 8'h00;
        if (c >= 8'd48 && c < 8'd58)
        begin
            code = num_code(4'(c - 8'd48));
        end
        else if (c == 8'd67 || c == 8'd91)
        begin
            code = CODE_C;
        end
        else if (c == 8'd65)
        begin
            code = CODE_A;
        end
        else if (c == 8'd93)
        begin
            code = CODE_CLOSE;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

[src/dsm_tick_ctrl.sv]
// Refresh timing for the segment multiplexer: tick counter and active digit.
// Depends on dsm_pkg for the tick status struct.
`default_nettype none

module dsm_tick_ctrl
    import dsm_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         tick,
    input  wire logic [7:0]   divider,
    output tick_status_t      status
);

    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic       active_reg;
    logic       active_next;
    logic [7:0] div_eff;
    logic [7:0] count_inc;
    logic       emit;

    // Saturating count, a zero divider acts as one
    always_comb
    begin
        div_eff   = (divider == 8'd0) ? 8'd1 : divider;
        count_inc = (count_reg != 8'hFF) ? count_reg + 8'd1 : count_reg;
        emit      = tick && (count_inc >= div_eff);
    end

    // Advance the counter and the digit on a refreshing tick
    always_comb
    begin
        count_next  = count_reg;
        active_next = active_reg;
        if (tick)
        begin
            count_next = emit ? 8'd0 : count_inc;
        end
        if (emit)
        begin
            active_next = (DIGIT_COUNT > 1) ? ~active_reg : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 8'd0;
            active_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            active_reg <= active_next;
        end
    end

    assign status.emit  = emit;
    assign status.digit = active_reg;

endmodule

`default_nettype wire

[src/two_digit_segment_multiplexer_unit.sv]
// Two-digit multiplexed seven-segment driver, top level.
// Depends on dsm_pkg and dsm_tick_ctrl.
//
//  channel  | direction | tdata                                   | tuser
//  s_axis   | in        | value, char_first, char_second, dot_index, dot_on | command
//  m_axis   | out       | segments                                | digit_select
//  cfg      | in        | cfg_wdata = refresh_divider (cfg_we)    | -
//
// One item per cycle while the result is not stalled: an input register, then one
// pass of table lookups and register updates into the result register.
// A held result blocks the input stage only while it is not taken.
// Reset clears the digit codes, dots, tick count and active digit, and sets
// the divider to two.
`default_nettype none

module two_digit_segment_multiplexer_unit
    import dsm_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // value[15:0], char_first[23:16], char_second[31:24], dot_index[32],
    // dot_on[33], zero fill [39:34]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // segments[7:0]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // digit_select[0]
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic                   cfg_we,
    input  wire logic [7:0]             cfg_wdata
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [2:0]   cmd_reg;
    logic [15:0]  value_reg;
    logic [7:0]   char_first_reg;
    logic [7:0]   char_second_reg;
    logic         dot_index_reg;
    logic         dot_on_reg;

    logic [7:0]   divider_reg;
    logic [7:0]   codes_reg [2];
    logic [7:0]   codes_next [2];
    logic [1:0]   dots_reg;
    logic [1:0]   dots_next;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [7:0]   seg_reg;
    logic         digit_reg;

    logic         out_free;
    logic         fire;
    logic         accept;
    logic [1:0]   dot_bit;
    tick_status_t tick_status;

    // Handshake: the input stage moves on whenever the result slot is free
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg         <= s_axis_tuser;
            value_reg       <= s_axis_tdata[15:0];
            char_first_reg  <= s_axis_tdata[23:16];
            char_second_reg <= s_axis_tdata[31:24];
            dot_index_reg   <= s_axis_tdata[32];
            dot_on_reg      <= s_axis_tdata[33];
        end
    end

    // Refresh timing
    dsm_tick_ctrl #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_tick_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (fire && (cmd_reg == CMD_TICK)),
        .divider (divider_reg),
        .status  (tick_status)
    );

    // Decode the command into new digit codes and dots
    always_comb
    begin
        codes_next[0] = codes_reg[0];
        codes_next[1] = codes_reg[1];
        dots_next     = dots_reg;
        dot_bit       = 2'b01 << dot_index_reg;
        if (fire)
        begin
            unique case (cmd_reg)
                CMD_NUM:
                begin
                    if (DIGIT_COUNT > 1)
                    begin
                        codes_next[1] = num_code(mod10(value_reg[7:0]));
                        codes_next[0] = num_code(mod10({3'd0, div10(value_reg[7:0])}));
                    end
                    else
                    begin
                        codes_next[0] = num_code(mod10(value_reg[7:0]));
                    end
                end
                CMD_TEXT:
                begin
                    codes_next[0] = char_code(char_first_reg);
                    if (DIGIT_COUNT > 1)
                    begin
                        codes_next[1] = char_code(char_second_reg);
                    end
                end
                CMD_RAW:
                begin
                    codes_next[0] = value_reg[7:0];
                    codes_next[1] = value_reg[15:8];
                end
                CMD_DOTS:
                begin
                    dots_next = value_reg[1:0];
                end
                CMD_DOT:
                begin
                    dots_next = dot_on_reg ? (dots_reg | dot_bit) : (dots_reg & ~dot_bit);
                end
                CMD_CLEAR:
                begin
                    codes_next[0] = 8'd0;
                    if (DIGIT_COUNT > 1)
                    begin
                        codes_next[1] = 8'd0;
                    end
                end
                default:
                begin
                    // tick and the unused code leave the display as it is
                end
            endcase
        end
    end

    // Display state and divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg[0] <= 8'd0;
            codes_reg[1] <= 8'd0;
            dots_reg     <= 2'b00;
            divider_reg  <= DIVIDER_RESET;
        end
        else
        begin
            codes_reg[0] <= codes_next[0];
            codes_reg[1] <= codes_next[1];
            dots_reg     <= dots_next;
            if (cfg_we)
            begin
                divider_reg <= cfg_wdata;
            end
        end
    end

    // Result register: load on a refreshing tick, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && tick_status.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && tick_status.emit)
        begin
            seg_reg   <= codes_reg[tick_status.digit]
                         | {7'd0, dots_reg[tick_status.digit]};
            digit_reg <= tick_status.digit;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = seg_reg;
    assign m_axis_tuser  = digit_reg;

endmodule

`default_nettype wire

[src/dsm_checker.sv]
// Port-level checks for the two-digit segment multiplexer, bound to the top level.
// Depends on dsm_pkg for command codes and stream widths.
`default_nettype none

module dsm_checker
    import dsm_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready
);

    logic expect_digit_reg;
    logic in_acc;
    logic out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Track the digit the next result must drive
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_digit_reg <= 1'b0;
        end
        else if (out_acc)
        begin
            expect_digit_reg <= (DIGIT_COUNT > 1) ? ~expect_digit_reg : 1'b0;
        end
    end

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Results walk the digits in turn
    a_digit_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> m_axis_tuser[0] == expect_digit_reg)
        else $error("digit select out of order");

    // The input side stalls only behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // A fresh result follows a taken tick item, through the input and result registers
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_acc && (s_axis_tuser == CMD_TICK), 2))
        else $error("result without a tick item");

endmodule

bind two_digit_segment_multiplexer_unit dsm_checker #(
    .DIGIT_COUNT (DIGIT_COUNT)
) u_dsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

[test/tb_two_digit_segment_multiplexer_unit.sv]
// Self-checking testbench for two_digit_segment_multiplexer_unit: directed command
// checks, divider corner cases, output back-pressure and long random command mixes.
// Depends on dsm_pkg and the RTL of the block; an internal predictor supplies expectations.
`timescale 1ns / 1ps

module tb_two_digit_segment_multiplexer_unit;
    import dsm_pkg::*;

    localparam int          LIMIT_CYCLES = 600000;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          PHASE_ITEMS  = 120;
    // Code 7 is not a command; the block must ignore it
    localparam logic [2:0]  CMD_NONE     = 3'd7;

    // Segment patterns of the decimal digits 0..9
    localparam logic [7:0] DIGIT_SEGS [10] = '{
        8'b11111100, 8'b01100000, 8'b11011010, 8'b11110010, 8'b01100110,
        8'b10110110, 8'b10111110, 8'b11100000, 8'b11111110, 8'b11110110
    };
    localparam logic [7:0] SEGS_C     = 8'b10011100;
    localparam logic [7:0] SEGS_A     = 8'b11101110;
    localparam logic [7:0] SEGS_CLOSE = 8'b11110000;

    // Glyph characters and their neighbors: C A [ ] / : B backslash
    localparam logic [7:0] PICK_CHARS [8] = '{
        8'h43, 8'h41, 8'h5B, 8'h5D, 8'h2F, 8'h3A, 8'h42, 8'h5C
    };

    typedef struct packed {
        logic [7:0] segs;
        logic       digit;
    } refresh_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [7:0]             cfg_wdata     = 8'd0;

    // Predicted display state
    logic [7:0] exp_divider;
    logic [7:0] exp_codes [2];
    logic [1:0] exp_dots;
    logic [7:0] exp_ticks;
    logic       exp_digit;
    refresh_t   refresh_q [$];

    // Idling controls and bookkeeping
    bit tx_gaps;
    bit rx_stalls;
    int rx_wait;
    int hold_cycles;
    int fail_count;
    int mismatch_count;
    int items_sent;
    int refreshes_seen;
    int cmd_hist [8];

    two_digit_segment_multiplexer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Map one character to its segment pattern, blank when there is none
    function automatic logic [7:0] glyph(input logic [7:0] c);
        logic [7:0] g;
        g = 8'h00;
        case (c)
            "C", "[": g = SEGS_C;
            "A":      g = SEGS_A;
            "]":      g = SEGS_CLOSE;
            default:
            begin
                if (c >= "0" && c <= "9")
                begin
                    g = DIGIT_SEGS[c - "0"];
                end
            end
        endcase
        return g;
    endfunction

    // Advance the predicted display by one accepted item, queue any refresh it causes
    task automatic predict_refresh(input logic [2:0] cmd, input logic [15:0] value,
                                   input logic [7:0] c1, input logic [7:0] c2,
                                   input logic didx, input logic don);
        refresh_t   r;
        logic [7:0] lim;
        int         n;
        case (cmd)
            CMD_TICK:
            begin
                lim = (exp_divider == 8'd0) ? 8'd1 : exp_divider;
                if (exp_ticks != 8'hFF)
                begin
                    exp_ticks = exp_ticks + 8'd1;
                end
                if (exp_ticks >= lim)
                begin
                    exp_ticks = 8'd0;
                    r.segs    = exp_codes[exp_digit] | {7'd0, exp_dots[exp_digit]};
                    r.digit   = exp_digit;
                    refresh_q.push_back(r);
                    exp_digit = ~exp_digit;
                end
            end
            CMD_NUM:
            begin
                n = int'(value[7:0]);
                exp_codes[1] = DIGIT_SEGS[n % 10];
                exp_codes[0] = DIGIT_SEGS[(n / 10) % 10];
            end
            CMD_TEXT:
            begin
                exp_codes[0] = glyph(c1);
                exp_codes[1] = glyph(c2);
            end
            CMD_RAW:
            begin
                exp_codes[0] = value[7:0];
                exp_codes[1] = value[15:8];
            end
            CMD_DOTS:  exp_dots = value[1:0];
            CMD_DOT:   exp_dots[didx] = don;
            CMD_CLEAR:
            begin
                exp_codes[0] = 8'h00;
                exp_codes[1] = 8'h00;
            end
            default:;
        endcase
    endtask

    // Offer one item after an optional gap, hold it until taken, then predict
    task automatic send_item(input logic [2:0] cmd, input logic [15:0] value,
                             input logic [7:0] c1, input logic [7:0] c2,
                             input logic didx, input logic don);
        int gap;
        int r;
        gap = 0;
        if (tx_gaps)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(8, 30);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, don, didx, c2, c1, value};
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        predict_refresh(cmd, value, c1, c2, didx, don);
        items_sent++;
        cmd_hist[cmd]++;
    endtask

    task automatic tick();
        send_item(CMD_TICK, 16'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom));
    endtask

    // Write the divider once the block has gone quiet
    task automatic write_divider(input logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (refresh_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        exp_divider  = v;
    endtask

    // Compare one taken refresh with the oldest prediction
    task automatic check_refresh();
        refresh_t e;
        if (refresh_q.size() == 0)
        begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected refresh segs=%02h digit=%0d",
                         $realtime, m_axis_tdata, m_axis_tuser[0]);
        end
        else
        begin
            e = refresh_q.pop_front();
            refreshes_seen++;
            if (m_axis_tdata !== e.segs || m_axis_tuser[0] !== e.digit)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"%0t: refresh %0d expected segs=%02h digit=%0d, ",
                              "got segs=%02h digit=%0d"},
                             $realtime, refreshes_seen, e.segs, e.digit,
                             m_axis_tdata, m_axis_tuser[0]);
            end
        end
    endtask

    // Take results and drive the output ready: forced hold, random stalls or always ready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_refresh();
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles    = hold_cycles - 1;
        end
        else if (!rx_stalls)
            m_axis_tready <= 1'b1;
        else if (rx_wait > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_wait        = rx_wait - 1;
        end
        else if ($urandom_range(0, 99) < 20)
        begin
            m_axis_tready <= 1'b0;
            rx_wait        = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Pick a character, weighted toward the ones with a glyph and their neighbors
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(48, 57));
        else if (r < 70)
            return PICK_CHARS[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one random item; every field carries random bits whatever the command
    task automatic random_item();
        int         r;
        logic [2:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 50)      cmd = CMD_TICK;
        else if (r < 60) cmd = CMD_NUM;
        else if (r < 72) cmd = CMD_TEXT;
        else if (r < 80) cmd = CMD_RAW;
        else if (r < 86) cmd = CMD_DOTS;
        else if (r < 92) cmd = CMD_DOT;
        else if (r < 96) cmd = CMD_CLEAR;
        else             cmd = CMD_NONE;
        send_item(cmd, 16'($urandom), pick_char(), pick_char(),
                  1'($urandom), 1'($urandom));
    endtask

    // Blank display and reset divider straight after reset
    task automatic test_reset_state();
        repeat (6) tick();
    endtask

    // Each command at least once, with the field extremes and the glyph edge characters
    task automatic test_commands();
        write_divider(8'd1);
        send_item(CMD_NUM, 16'h00FF, 8'd0, 8'd0, 1'b0, 1'b0);
        tick();
        tick();
        send_item(CMD_TEXT, 16'h0000, "C", "A", 1'b0, 1'b0);
        tick();
        tick();
        send_item(CMD_TEXT, 16'h0000, "[", "]", 1'b0, 1'b0);
        send_item(CMD_DOTS, 16'h0003, 8'd0, 8'd0, 1'b0, 1'b0);
        tick();
        tick();
        send_item(CMD_TEXT, 16'h0000, "/", ":", 1'b0, 1'b0);
        send_item(CMD_DOT, 16'h0000, 8'd0, 8'd0, 1'b0, 1'b0);
        tick();
        tick();
        send_item(CMD_RAW, 16'hFFFF, 8'hFF, 8'h00, 1'b0, 1'b0);
        send_item(CMD_DOT, 16'h0000, 8'd0, 8'd0, 1'b1, 1'b0);
        tick();
        tick();
        send_item(CMD_CLEAR, 16'h0000, 8'd0, 8'd0, 1'b0, 1'b0);
        send_item(CMD_NONE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
        tick();
        tick();
        send_item(CMD_NUM, 16'hFF00, "9", "0", 1'b1, 1'b1);
        send_item(CMD_DOTS, 16'hFFFC, 8'hFF, 8'hFF, 1'b1, 1'b1);
        tick();
        tick();
    endtask

    // Lowered divider below the count, then divider zero
    task automatic test_divider_corners();
        write_divider(8'd5);
        send_item(CMD_NUM, 16'd42, 8'd0, 8'd0, 1'b0, 1'b0);
        repeat (4) tick();
        write_divider(8'd2);
        tick();
        write_divider(8'd0);
        repeat (6) tick();
    endtask

    // Largest divider, then lowered to one with a low count left
    task automatic test_divider_max();
        write_divider(8'd255);
        send_item(CMD_RAW, 16'hA55A, 8'd0, 8'd0, 1'b0, 1'b0);
        repeat (520) tick();
        write_divider(8'd1);
        repeat (3) tick();
    endtask

    // Hold off the output while the sender keeps offering items back to back
    task automatic test_backpressure();
        tx_gaps     = 1'b0;
        rx_stalls   = 1'b0;
        write_divider(8'd1);
        hold_cycles = 80;
        repeat (60) random_item();
        tx_gaps     = 1'b1;
        rx_stalls   = 1'b1;
    endtask

    // Random command mixes over several divider settings
    task automatic test_random_mix();
        logic [7:0] div;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       div = 8'd1;
                1:       div = 8'd2;
                2:       div = 8'($urandom_range(3, 9));
                3:       div = 8'd0;
                4:       div = 8'($urandom_range(1, 16));
                default: div = 8'($urandom_range(1, 5));
            endcase
            // One phase runs without any idling on either side
            tx_gaps   = (p != 4);
            rx_stalls = (p != 4);
            write_divider(div);
            repeat (PHASE_ITEMS) random_item();
        end
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial
    begin
        exp_divider = DIVIDER_RESET;
        exp_codes   = '{8'h00, 8'h00};
        exp_dots    = 2'b00;
        exp_ticks   = 8'd0;
        exp_digit   = 1'b0;
        tx_gaps     = 1'b1;
        rx_stalls   = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_commands();
        test_divider_corners();
        test_divider_max();
        test_backpressure();
        test_random_mix();

        // Drain the remaining refreshes
        s_axis_tvalid <= 1'b0;
        while (refresh_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count = fail_count + refresh_q.size();

        $display("Sent %0d items (%0d ticks, %0d text, %0d number, %0d ignored code 7),",
                 items_sent, cmd_hist[CMD_TICK], cmd_hist[CMD_TEXT], cmd_hist[CMD_NUM],
                 cmd_hist[CMD_NONE]);
        $display("checked %0d refreshes with dividers 0, 1, 255 and random; %0d failures.",
                 refreshes_seen, fail_count);
        if (fail_count == 0)
            $display("two_digit_segment_multiplexer_unit: match");
        else
            $display("two_digit_segment_multiplexer_unit: mismatch");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("Timeout with %0d refreshes outstanding", refresh_q.size());
        $display("two_digit_segment_multiplexer_unit: mismatch");
        $finish;
    end

endmodule
